// ----- src/lptc_pkg.sv -----
// lptc_pkg: shared types and constants for the lidar point transform and crop block
// no dependencies
package lptc_pkg;

  // default coordinate width (signed Q8.8 at 16 bits)
  localparam int unsigned COORD_WIDTH_DEF = 16;

  // trig values are signed Q1.14 in 16-bit fields
  localparam int unsigned TRIG_W    = 16;
  localparam int unsigned TRIG_FRAC = 14;

  // configuration field width and register port sizes
  localparam int unsigned FIELD_W   = 16;
  localparam int unsigned REG_W     = 32;
  localparam int unsigned PDATA_W   = 64;
  localparam int unsigned PADDR_W   = 6;

  // reset value of every rotation register: cos = 1.0, sin = 0
  localparam logic [REG_W-1:0] ROT_RESET = 32'h4000_0000;

  // configuration register indexes (byte address = 8 * index)
  typedef enum logic [2:0] {
    REG_SENSOR_A_ROT = 3'd0,
    REG_SENSOR_A_OFS = 3'd1,
    REG_SENSOR_B_ROT = 3'd2,
    REG_SENSOR_B_OFS = 3'd3,
    REG_BODY_HALF    = 3'd4,
    REG_POSE_ROT     = 3'd5,
    REG_POSE_OFS     = 3'd6,
    REG_CROP_BOUNDS  = 3'd7
  } reg_idx_e;

  // drop reason codes on the result
  typedef enum logic [1:0] {
    DROP_NONE = 2'd0,
    DROP_BODY = 2'd1,
    DROP_CROP = 2'd2
  } drop_e;

  // stage load enables for one rotate unit
  typedef struct packed {
    logic mul_en;
    logic sum_en;
  } rot_ctrl_t;

endpackage

// ----- src/lidar_point_transform_crop.sv -----
// lidar_point_transform_crop: top level, config registers, pipeline control, body and crop tests
// depends on lptc_pkg and lptc_rotate
//
// Usage: each request on the input channel (in_valid_i / in_ready_o) carries one
// point (point_x_i, point_y_i, signed Q8.8) and a sensor select (mode_i). Every
// request gives exactly one result on the output channel (out_valid_o /
// out_ready_i): keep_o, drop_reason_o and the world point (zero when dropped).
// Five register stages: sensor multiply, sensor sum, pose multiply plus body
// test, pose sum, crop test into the output register. The accepting edge loads
// the first stage and each later stage takes the point in turn; throughput is
// one point per cycle while the receiver takes results, set by the fully
// pipelined multipliers of the two rotate units.
// Each stage has its own valid bit and loads when it is empty or the stage
// after it moves, so bubbles close up and new requests are taken while a
// result waits. A stalled receiver fills the pipeline, and only then does
// in_ready_o fall; nothing is lost or repeated.
// Reset (rst_ni low, asynchronous) empties the pipeline and sets the
// calibration registers to identity rotations and zero offsets and bounds.
// Configuration goes through the APB port at byte address 8 * index; write it
// only while the pipeline is empty.
module lidar_point_transform_crop
  import lptc_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // point channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          mode_i,
  input  logic signed [COORD_WIDTH-1:0] point_x_i,
  input  logic signed [COORD_WIDTH-1:0] point_y_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          keep_o,
  output logic [1:0]                    drop_reason_o,
  output logic signed [COORD_WIDTH-1:0] world_x_o,
  output logic signed [COORD_WIDTH-1:0] world_y_o,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [PADDR_W-1:0]            paddr,
  input  logic [PDATA_W-1:0]            pwdata,
  output logic [PDATA_W-1:0]            prdata,
  output logic                          pready
);

  // vehicle frame and world frame widths, wide enough that nothing wraps
  localparam int unsigned VW = ((COORD_WIDTH + 3 > FIELD_W) ? COORD_WIDTH + 3 : FIELD_W) + 1;
  localparam int unsigned WW = ((VW + 3 > FIELD_W) ? VW + 3 : FIELD_W) + 1;

  // configuration registers
  logic [REG_W-1:0]   sa_rot_q, sa_ofs_q, sb_rot_q, sb_ofs_q;
  logic [REG_W-1:0]   body_q, pose_rot_q, pose_ofs_q;
  logic [PDATA_W-1:0] crop_q;
  logic               cfg_wr;
  reg_idx_e           cfg_idx;

  // pipeline control
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  // stage payload
  logic                 mode_s1_q;
  logic [FIELD_W-1:0]   cos_a, sin_a;
  logic [REG_W-1:0]     ofs_a;
  rot_ctrl_t            ctrl_a, ctrl_b;
  logic signed [VW-1:0] vx, vy;
  logic signed [WW-1:0] wx, wy;
  logic signed [VW:0]   vx_e, vy_e, hl_s, hw_s;
  logic                 in_body;
  logic                 body_s3_q, body_s4_q;
  logic signed [WW-1:0] floor_e, ceil_e, right_e, left_e;
  logic                 out_crop;

  // result register
  logic                          keep_q;
  drop_e                         reason_q;
  logic signed [COORD_WIDTH-1:0] wx_q, wy_q;

  // apb write decode
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = reg_idx_e'(paddr[PADDR_W-1:3]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sa_rot_q   <= ROT_RESET;
      sa_ofs_q   <= '0;
      sb_rot_q   <= ROT_RESET;
      sb_ofs_q   <= '0;
      body_q     <= '0;
      pose_rot_q <= ROT_RESET;
      pose_ofs_q <= '0;
      crop_q     <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_SENSOR_A_ROT: sa_rot_q   <= pwdata[REG_W-1:0];
        REG_SENSOR_A_OFS: sa_ofs_q   <= pwdata[REG_W-1:0];
        REG_SENSOR_B_ROT: sb_rot_q   <= pwdata[REG_W-1:0];
        REG_SENSOR_B_OFS: sb_ofs_q   <= pwdata[REG_W-1:0];
        REG_BODY_HALF:    body_q     <= pwdata[REG_W-1:0];
        REG_POSE_ROT:     pose_rot_q <= pwdata[REG_W-1:0];
        REG_POSE_OFS:     pose_ofs_q <= pwdata[REG_W-1:0];
        REG_CROP_BOUNDS:  crop_q     <= pwdata;
        default: ;
      endcase
    end
  end

  // apb read mux
  always_comb begin
    case (cfg_idx)
      REG_SENSOR_A_ROT: prdata = PDATA_W'(sa_rot_q);
      REG_SENSOR_A_OFS: prdata = PDATA_W'(sa_ofs_q);
      REG_SENSOR_B_ROT: prdata = PDATA_W'(sb_rot_q);
      REG_SENSOR_B_OFS: prdata = PDATA_W'(sb_ofs_q);
      REG_BODY_HALF:    prdata = PDATA_W'(body_q);
      REG_POSE_ROT:     prdata = PDATA_W'(pose_rot_q);
      REG_POSE_OFS:     prdata = PDATA_W'(pose_ofs_q);
      REG_CROP_BOUNDS:  prdata = crop_q;
      default:          prdata = '0;
    endcase
  end

  // per-stage ready: a stage loads when empty or when its contents move on
  assign rdy5       = ~v5_q | out_ready_i;
  assign rdy4       = ~v4_q | rdy5;
  assign rdy3       = ~v3_q | rdy4;
  assign rdy2       = ~v2_q | rdy3;
  assign rdy1       = ~v1_q | rdy2;
  assign in_ready_o = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
      if (rdy5) v5_q <= v4_q;
    end
  end

  // sensor calibration select
  assign cos_a = mode_i ? sb_rot_q[31:16] : sa_rot_q[31:16];
  assign sin_a = mode_i ? sb_rot_q[15:0]  : sa_rot_q[15:0];
  assign ofs_a = mode_s1_q ? sb_ofs_q : sa_ofs_q;

  always_ff @(posedge clk_i) begin
    if (rdy1) mode_s1_q <= mode_i;
  end

  // sensor frame to vehicle frame
  assign ctrl_a.mul_en = rdy1;
  assign ctrl_a.sum_en = rdy2;

  lptc_rotate #(
    .IN_W  (COORD_WIDTH),
    .OUT_W (VW)
  ) u_rot_sensor (
    .clk_i   (clk_i),
    .ctrl_i  (ctrl_a),
    .x_i     (point_x_i),
    .y_i     (point_y_i),
    .cos_i   ($signed(cos_a)),
    .sin_i   ($signed(sin_a)),
    .off_x_i ($signed(ofs_a[31:16])),
    .off_y_i ($signed(ofs_a[15:0])),
    .x_o     (vx),
    .y_o     (vy)
  );

  // body box test, inclusive on every edge
  assign vx_e    = (VW+1)'(vx);
  assign vy_e    = (VW+1)'(vy);
  assign hl_s    = $signed({{(VW+1-FIELD_W){1'b0}}, body_q[31:16]});
  assign hw_s    = $signed({{(VW+1-FIELD_W){1'b0}}, body_q[15:0]});
  assign in_body = (vx_e <= hl_s) && (vx_e >= -hl_s) &&
                   (vy_e <= hw_s) && (vy_e >= -hw_s);

  always_ff @(posedge clk_i) begin
    if (rdy3) body_s3_q <= in_body;
    if (rdy4) body_s4_q <= body_s3_q;
  end

  // vehicle frame to world frame
  assign ctrl_b.mul_en = rdy3;
  assign ctrl_b.sum_en = rdy4;

  lptc_rotate #(
    .IN_W  (VW),
    .OUT_W (WW)
  ) u_rot_pose (
    .clk_i   (clk_i),
    .ctrl_i  (ctrl_b),
    .x_i     (vx),
    .y_i     (vy),
    .cos_i   ($signed(pose_rot_q[31:16])),
    .sin_i   ($signed(pose_rot_q[15:0])),
    .off_x_i ($signed(pose_ofs_q[31:16])),
    .off_y_i ($signed(pose_ofs_q[15:0])),
    .x_o     (wx),
    .y_o     (wy)
  );

  // crop test, open box: a point on any bound is outside
  assign floor_e  = WW'($signed(crop_q[63:48]));
  assign ceil_e   = WW'($signed(crop_q[47:32]));
  assign right_e  = WW'($signed(crop_q[31:16]));
  assign left_e   = WW'($signed(crop_q[15:0]));
  assign out_crop = (wx <= floor_e) || (wx >= ceil_e) ||
                    (wy <= right_e) || (wy >= left_e);

  // result register
  always_ff @(posedge clk_i) begin
    if (rdy5) begin
      if (body_s4_q) begin
        keep_q   <= 1'b0;
        reason_q <= DROP_BODY;
        wx_q     <= '0;
        wy_q     <= '0;
      end else if (out_crop) begin
        keep_q   <= 1'b0;
        reason_q <= DROP_CROP;
        wx_q     <= '0;
        wy_q     <= '0;
      end else begin
        keep_q   <= 1'b1;
        reason_q <= DROP_NONE;
        wx_q     <= wx[COORD_WIDTH-1:0];
        wy_q     <= wy[COORD_WIDTH-1:0];
      end
    end
  end

  assign out_valid_o   = v5_q;
  assign keep_o        = keep_q;
  assign drop_reason_o = reason_q;
  assign world_x_o     = wx_q;
  assign world_y_o     = wy_q;

  // keep flag agrees with the drop reason
  a_keep_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (keep_o == (drop_reason_o == DROP_NONE)))
    else $error("keep flag and drop reason disagree");

  // dropped points carry a zero world point
  a_drop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !keep_o) |-> (world_x_o == '0 && world_y_o == '0))
    else $error("dropped point has nonzero coordinates");

  // only defined drop reasons appear
  a_reason_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (drop_reason_o == DROP_NONE || drop_reason_o == DROP_BODY ||
                     drop_reason_o == DROP_CROP))
    else $error("undefined drop reason");

  // input backpressure only when every stage is full
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (v1_q && v2_q && v3_q && v4_q && v5_q))
    else $error("input stalled with a bubble in the pipeline");

  // an accepted request lands in the first stage
  a_accept_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> v1_q)
    else $error("accepted request lost at the first stage");

endmodule

// ----- src/lptc_rotate.sv -----
// lptc_rotate: two-stage 2D rotation plus offset (multiply stage, then sum/shift/add stage)
// depends on lptc_pkg
module lptc_rotate
  import lptc_pkg::*;
#(
  parameter int unsigned IN_W  = 16,
  parameter int unsigned OUT_W = 20
) (
  input  logic                    clk_i,
  input  rot_ctrl_t               ctrl_i,
  input  logic signed [IN_W-1:0]  x_i,
  input  logic signed [IN_W-1:0]  y_i,
  input  logic signed [TRIG_W-1:0] cos_i,
  input  logic signed [TRIG_W-1:0] sin_i,
  input  logic signed [FIELD_W-1:0] off_x_i,
  input  logic signed [FIELD_W-1:0] off_y_i,
  output logic signed [OUT_W-1:0] x_o,
  output logic signed [OUT_W-1:0] y_o
);

  localparam int unsigned PW = IN_W + TRIG_W;
  localparam int unsigned SW = PW + 1;
  localparam int unsigned HW = SW - TRIG_FRAC;

  logic signed [PW-1:0]    cx_q, sy_q, sx_q, cy_q;
  logic signed [PW-1:0]    cx_d, sy_d, sx_d, cy_d;
  logic signed [SW-1:0]    sum_x, sum_y;
  logic signed [HW-1:0]    shx, shy;
  logic signed [OUT_W-1:0] x_d, y_d, x_q, y_q;

  // products, exact at PW bits
  assign cx_d = PW'(x_i) * PW'(cos_i);
  assign sy_d = PW'(y_i) * PW'(sin_i);
  assign sx_d = PW'(x_i) * PW'(sin_i);
  assign cy_d = PW'(y_i) * PW'(cos_i);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      cx_q <= cx_d;
      sy_q <= sy_d;
      sx_q <= sx_d;
      cy_q <= cy_d;
    end
  end

  // sum, floor shift by the trig fraction, add offset
  assign sum_x = SW'(cx_q) - SW'(sy_q);
  assign sum_y = SW'(sx_q) + SW'(cy_q);
  assign shx   = sum_x[SW-1:TRIG_FRAC];
  assign shy   = sum_y[SW-1:TRIG_FRAC];
  assign x_d   = OUT_W'(shx) + OUT_W'(off_x_i);
  assign y_d   = OUT_W'(shy) + OUT_W'(off_y_i);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.sum_en) begin
      x_q <= x_d;
      y_q <= y_d;
    end
  end

  assign x_o = x_q;
  assign y_o = y_q;

endmodule

// ----- tb/sv/lidar_point_transform_crop_test.sv -----
// lidar_point_transform_crop_test: self-checking bench for the lidar point transform and crop block
// streams points through sensor and pose transforms under several calibrations, checks each result
// depends on lptc_pkg and lidar_point_transform_crop
module lidar_point_transform_crop_test;
  import lptc_pkg::*;

  localparam int unsigned CW = COORD_WIDTH_DEF;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 10;
  localparam int N_PHASES = 10;

  typedef struct packed {
    logic          keep;
    drop_e         reason;
    logic [CW-1:0] wx;
    logic [CW-1:0] wy;
  } point_res_t;

  typedef struct {
    bit            is_cfg;
    reg_idx_e      idx;
    logic [63:0]   val;
    logic          m;
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    bit            typed;
    point_res_t    res;
  } stim_row_t;

  localparam point_res_t BODY_RES = '{1'b0, DROP_BODY, '0, '0};
  localparam point_res_t CROP_RES = '{1'b0, DROP_CROP, '0, '0};

  logic                   clk_i;
  logic                   rst_ni;
  logic                   in_valid_i;
  logic                   in_ready_o;
  logic                   mode_i;
  logic signed [CW-1:0]   point_x_i;
  logic signed [CW-1:0]   point_y_i;
  logic                   out_valid_o;
  logic                   out_ready_i;
  logic                   keep_o;
  logic [1:0]             drop_reason_o;
  logic signed [CW-1:0]   world_x_o;
  logic signed [CW-1:0]   world_y_o;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [PADDR_W-1:0]     paddr;
  logic [PDATA_W-1:0]     pwdata;
  logic [PDATA_W-1:0]     prdata;
  logic                   pready;

  lidar_point_transform_crop #(
    .COORD_WIDTH(CW)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .mode_i(mode_i),
    .point_x_i(point_x_i),
    .point_y_i(point_y_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .keep_o(keep_o),
    .drop_reason_o(drop_reason_o),
    .world_x_o(world_x_o),
    .world_y_o(world_y_o),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // calibration copy kept by the bench, updated at each register write
  logic [63:0] cfg_regs [8];
  point_res_t  pending_results [$];
  stim_row_t   rows [$];
  bit          typed_valid;
  point_res_t  typed_res;

  int n_points;
  int n_results;
  int n_kept;
  int n_body;
  int n_crop;
  int n_errors;
  int idle_cycles;
  int burst_left;
  int rx_style;
  int style_left;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // one rigid transform: rotate in Q1.14, floor shift, then offset
  function automatic void rotate_fixed(input logic [31:0] rot, input logic [31:0] ofs,
                                       input longint x, input longint y,
                                       output longint ox, output longint oy);
    longint c, s, dx, dy;
    c = longint'($signed(rot[31:16]));
    s = longint'($signed(rot[15:0]));
    dx = longint'($signed(ofs[31:16]));
    dy = longint'($signed(ofs[15:0]));
    ox = ((c * x - s * y) >>> TRIG_FRAC) + dx;
    oy = ((s * x + c * y) >>> TRIG_FRAC) + dy;
  endfunction

  // expected result of one point under the current calibration
  function automatic point_res_t transform_point(input logic m, input logic signed [CW-1:0] x,
                                                 input logic signed [CW-1:0] y);
    point_res_t  r;
    longint      vx, vy, wx, wy, half_len, half_wid, x_lo, x_hi, y_lo, y_hi;
    logic [63:0] crop;
    r = '0;
    if (m) begin
      rotate_fixed(cfg_regs[REG_SENSOR_B_ROT][31:0], cfg_regs[REG_SENSOR_B_OFS][31:0],
                   longint'(x), longint'(y), vx, vy);
    end else begin
      rotate_fixed(cfg_regs[REG_SENSOR_A_ROT][31:0], cfg_regs[REG_SENSOR_A_OFS][31:0],
                   longint'(x), longint'(y), vx, vy);
    end
    // body box test, edges count as inside
    half_len = longint'(cfg_regs[REG_BODY_HALF][31:16]);
    half_wid = longint'(cfg_regs[REG_BODY_HALF][15:0]);
    if ((vx < 0 ? -vx : vx) <= half_len && (vy < 0 ? -vy : vy) <= half_wid) begin
      r.reason = DROP_BODY;
      return r;
    end
    rotate_fixed(cfg_regs[REG_POSE_ROT][31:0], cfg_regs[REG_POSE_OFS][31:0], vx, vy, wx, wy);
    // crop window is open on all four sides
    crop = cfg_regs[REG_CROP_BOUNDS];
    x_lo = longint'($signed(crop[63:48]));
    x_hi = longint'($signed(crop[47:32]));
    y_lo = longint'($signed(crop[31:16]));
    y_hi = longint'($signed(crop[15:0]));
    if (wx <= x_lo || wx >= x_hi || wy <= y_lo || wy >= y_hi) begin
      r.reason = DROP_CROP;
    end else begin
      r.keep = 1'b1;
      r.wx = wx[CW-1:0];
      r.wy = wy[CW-1:0];
    end
    return r;
  endfunction

  function automatic point_res_t kept_at(input logic [CW-1:0] x, input logic [CW-1:0] y);
    point_res_t r;
    r.keep = 1'b1;
    r.reason = DROP_NONE;
    r.wx = x;
    r.wy = y;
    return r;
  endfunction

  // table row builders
  function automatic stim_row_t cfg_row(input reg_idx_e idx, input logic [63:0] val);
    stim_row_t r;
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.val = val;
    r.m = 1'b0;
    r.x = '0;
    r.y = '0;
    r.typed = 1'b0;
    r.res = '0;
    return r;
  endfunction

  function automatic stim_row_t pt_row(input logic m, input logic [CW-1:0] x,
                                       input logic [CW-1:0] y);
    stim_row_t r;
    r.is_cfg = 1'b0;
    r.idx = REG_SENSOR_A_ROT;
    r.val = '0;
    r.m = m;
    r.x = x;
    r.y = y;
    r.typed = 1'b0;
    r.res = '0;
    return r;
  endfunction

  function automatic stim_row_t pt_typed(input logic m, input logic [CW-1:0] x,
                                         input logic [CW-1:0] y, input point_res_t res);
    stim_row_t r;
    r = pt_row(m, x, y);
    r.typed = 1'b1;
    r.res = res;
    return r;
  endfunction

  // append one row to the stimulus table
  function automatic void add_row(input stim_row_t r);
    rows.insert(rows.size(), r);
  endfunction

  // random helpers
  function automatic logic [CW-1:0] rand_coord(input int span);
    int v;
    v = int'($urandom_range(0, 2 * span)) - span;
    return CW'(v);
  endfunction

  function automatic logic [31:0] rand_rotation();
    int c, s;
    int unsigned k;
    k = $urandom_range(0, 7);
    case (k)
      0: begin c = 16384; s = 0; end
      1: begin c = 0; s = 16384; end
      2: begin c = 11585; s = 11585; end
      3: begin c = 14189; s = 8192; end
      4: begin c = 8192; s = 14189; end
      5: begin c = 15137; s = 6270; end
      6: begin c = 6270; s = 15137; end
      default: begin c = $urandom(); s = $urandom(); end
    endcase
    if (k < 7) begin
      if ($urandom_range(0, 1)) c = -c;
      if ($urandom_range(0, 1)) s = -s;
    end
    return {16'(c), 16'(s)};
  endfunction

  // register write: setup then access, junk in unused upper data bits
  task automatic write_reg(input reg_idx_e idx, input logic [63:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 3'b000};
    pwdata <= (idx == REG_CROP_BOUNDS) ? val : {$urandom(), val[31:0]};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    cfg_regs[idx] = (idx == REG_CROP_BOUNDS) ? val : {32'h0, val[31:0]};
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  // present one request, with a random gap at the start of each burst
  task automatic send_point(input logic m, input logic [CW-1:0] x, input logic [CW-1:0] y,
                            input bit typed, input point_res_t res);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      case ($urandom_range(0, 3))
        0: gap = 0;
        1: gap = $urandom_range(1, 3);
        2: gap = $urandom_range(1, 10);
        default: gap = $urandom_range(10, 25);
      endcase
    end
    burst_left--;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= m;
    point_x_i <= x;
    point_y_i <= y;
    typed_valid = typed;
    typed_res = res;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // hold off new requests until every result is back
  task automatic drain_points();
    in_valid_i <= 1'b0;
    typed_valid = 1'b0;
    do @(negedge clk_i); while (pending_results.size() != 0);
  endtask

  // calibration for one random phase: extremes first, then realistic mounts
  task automatic configure_phase(input int ph);
    logic [63:0] vals [8];
    case (ph)
      0: begin
        vals[REG_SENSOR_A_ROT] = 64'h7FFF_7FFF;
        vals[REG_SENSOR_A_OFS] = 64'h7FFF_7FFF;
        vals[REG_SENSOR_B_ROT] = 64'h7FFF_7FFF;
        vals[REG_SENSOR_B_OFS] = 64'h7FFF_7FFF;
        vals[REG_BODY_HALF]    = 64'h0;
        vals[REG_POSE_ROT]     = 64'h7FFF_7FFF;
        vals[REG_POSE_OFS]     = 64'h7FFF_7FFF;
        vals[REG_CROP_BOUNDS]  = 64'h8000_7FFF_8000_7FFF;
      end
      1: begin
        vals[REG_SENSOR_A_ROT] = 64'h8000_8000;
        vals[REG_SENSOR_A_OFS] = 64'h8000_8000;
        vals[REG_SENSOR_B_ROT] = 64'h8000_8000;
        vals[REG_SENSOR_B_OFS] = 64'h8000_8000;
        vals[REG_BODY_HALF]    = 64'hFFFF_FFFF;
        vals[REG_POSE_ROT]     = 64'h8000_8000;
        vals[REG_POSE_OFS]     = 64'h8000_8000;
        vals[REG_CROP_BOUNDS]  = 64'hFFFF_FFFF_FFFF_FFFF;
      end
      2: begin
        vals[REG_SENSOR_A_ROT] = 64'h0;
        vals[REG_SENSOR_A_OFS] = {32'h0, rand_coord('h0400), rand_coord('h0400)};
        vals[REG_SENSOR_B_ROT] = 64'h0;
        vals[REG_SENSOR_B_OFS] = {32'h0, rand_coord('h0400), rand_coord('h0400)};
        vals[REG_BODY_HALF]    = {32'h0, 16'h0100, 16'h0100};
        vals[REG_POSE_ROT]     = {32'h0, rand_rotation()};
        vals[REG_POSE_OFS]     = {32'h0, rand_coord('h1000), rand_coord('h1000)};
        vals[REG_CROP_BOUNDS]  = 64'h8000_7FFF_8000_7FFF;
      end
      default: begin
        vals[REG_SENSOR_A_ROT] = {32'h0, rand_rotation()};
        vals[REG_SENSOR_A_OFS] = {32'h0, rand_coord('h0300), rand_coord('h0300)};
        vals[REG_SENSOR_B_ROT] = {32'h0, rand_rotation()};
        vals[REG_SENSOR_B_OFS] = {32'h0, rand_coord('h0300), rand_coord('h0300)};
        vals[REG_BODY_HALF]    = {32'h0, 16'($urandom_range(0, 'h0300)),
                                  16'($urandom_range(0, 'h0200))};
        vals[REG_POSE_ROT]     = {32'h0, rand_rotation()};
        vals[REG_POSE_OFS]     = {32'h0, rand_coord('h0800), rand_coord('h0800)};
        if ($urandom_range(0, 5) == 0) begin
          vals[REG_CROP_BOUNDS] = {$urandom(), $urandom()};
        end else begin
          vals[REG_CROP_BOUNDS] = {CW'(-int'($urandom_range(16'h0400, 16'h7000))),
                                   CW'($urandom_range(16'h0400, 16'h7FFF)),
                                   CW'(-int'($urandom_range(16'h0400, 16'h7000))),
                                   CW'($urandom_range(16'h0400, 16'h7FFF))};
        end
      end
    endcase
    for (int r = 0; r < 8; r++) begin
      write_reg(reg_idx_e'(r), vals[r]);
    end
  endtask

  // receiver stalls: ready follows a random style, picked anew after each random run
  always @(negedge clk_i) begin
    if (style_left == 0) begin
      style_left = $urandom_range(16, 120);
      rx_style = $urandom_range(0, 3);
    end
    style_left--;
    case (rx_style)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= 1'($urandom_range(0, 1));
      2: out_ready_i <= ($urandom_range(0, 5) == 0);
      default: out_ready_i <= ($urandom_range(0, 15) != 0);
    endcase
  end

  // record accepted requests, check accepted results against the oldest expectation
  always @(posedge clk_i) begin : check_results
    point_res_t got, want, exp_res;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        n_points++;
        if (typed_valid) begin
          exp_res = typed_res;
        end else begin
          exp_res = transform_point(mode_i, point_x_i, point_y_i);
        end
        pending_results.insert(pending_results.size(), exp_res);
      end
      if (out_valid_o && out_ready_i) begin
        n_results++;
        got.keep = keep_o;
        got.reason = drop_e'(drop_reason_o);
        got.wx = world_x_o;
        got.wy = world_y_o;
        if (got.keep) n_kept++;
        else if (got.reason == DROP_BODY) n_body++;
        else n_crop++;
        if (pending_results.size() == 0) begin
          if (n_errors < 10) $display("result %0d arrived with nothing pending", n_results);
          n_errors++;
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            if (n_errors < 10) begin
              $display("result %0d: expected keep=%0d reason=%0d x=%h y=%h, got keep=%0d reason=%0d x=%h y=%h",
                       n_results, want.keep, want.reason, want.wx, want.wy,
                       got.keep, got.reason, got.wx, got.wy);
            end
            n_errors++;
          end
        end
      end
    end
  end

  // watchdog on cycles without any accepted request or result
  always @(posedge clk_i) begin
    if (rst_ni && !((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))) begin
      idle_cycles++;
    end else begin
      idle_cycles = 0;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d idle cycles, %0d results pending",
               idle_cycles, pending_results.size());
      $display("tb: failure");
      $finish;
    end
  end

  // stimulus
  initial begin : stimulus
    int            n_items;
    logic          m;
    logic [CW-1:0] x, y;

    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    mode_i = 1'b0;
    point_x_i = '0;
    point_y_i = '0;
    out_ready_i = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = '0;
    pwdata = '0;
    typed_valid = 1'b0;
    typed_res = '0;
    burst_left = 0;
    style_left = 0;
    rx_style = 0;
    idle_cycles = 0;
    n_points = 0;
    n_results = 0;
    n_kept = 0;
    n_body = 0;
    n_crop = 0;
    n_errors = 0;
    for (int r = 0; r < 8; r++) cfg_regs[r] = 64'h0;
    cfg_regs[REG_SENSOR_A_ROT] = {32'h0, ROT_RESET};
    cfg_regs[REG_SENSOR_B_ROT] = {32'h0, ROT_RESET};
    cfg_regs[REG_POSE_ROT] = {32'h0, ROT_RESET};

    // reset calibration: identity transforms, zero-size body box at the origin, empty crop window
    add_row(pt_typed(1'b0, 16'h0000, 16'h0000, BODY_RES));
    add_row(pt_typed(1'b1, 16'h0000, 16'h0000, BODY_RES));
    add_row(pt_typed(1'b0, 16'h7FFF, 16'h7FFF, CROP_RES));
    add_row(pt_typed(1'b1, 16'h8000, 16'h8000, CROP_RES));
    add_row(pt_typed(1'b0, 16'h0001, 16'h0000, CROP_RES));
    // body box and crop window edges, transforms still identity
    add_row(cfg_row(REG_BODY_HALF, 64'h0100_0080));
    add_row(cfg_row(REG_CROP_BOUNDS, 64'hC000_4000_C000_4000));
    add_row(pt_typed(1'b0, 16'h0100, 16'h0080, BODY_RES));
    add_row(pt_typed(1'b1, 16'hFF00, 16'hFF80, BODY_RES));
    add_row(pt_typed(1'b0, 16'h0101, 16'h0000, kept_at(16'h0101, 16'h0000)));
    add_row(pt_typed(1'b1, 16'h0000, 16'h0081, kept_at(16'h0000, 16'h0081)));
    add_row(pt_typed(1'b0, 16'h4000, 16'h0000, CROP_RES));
    add_row(pt_typed(1'b0, 16'hC000, 16'h1000, CROP_RES));
    add_row(pt_typed(1'b1, 16'h1000, 16'h4000, CROP_RES));
    add_row(pt_typed(1'b1, 16'h3FFF, 16'hC001, kept_at(16'h3FFF, 16'hC001)));
    // real rotations and offsets on both sensors and the pose
    add_row(cfg_row(REG_SENSOR_A_ROT, 64'h0000_4000));
    add_row(cfg_row(REG_SENSOR_A_OFS, 64'h0100_FF00));
    add_row(cfg_row(REG_SENSOR_B_ROT, 64'h2D41_D2BF));
    add_row(cfg_row(REG_SENSOR_B_OFS, 64'hFE80_0040));
    add_row(cfg_row(REG_POSE_ROT, 64'h376D_2000));
    add_row(cfg_row(REG_POSE_OFS, 64'h0500_FB00));
    add_row(cfg_row(REG_CROP_BOUNDS, 64'h8000_7FFF_8000_7FFF));
    add_row(pt_row(1'b0, 16'h0123, 16'hFEDC));
    add_row(pt_row(1'b1, 16'hFFFF, 16'h0001));
    add_row(pt_row(1'b0, 16'h7FFF, 16'h8000));
    add_row(pt_row(1'b1, 16'h8000, 16'h7FFF));
    add_row(pt_row(1'b0, 16'h0000, 16'h0000));
    add_row(pt_row(1'b1, 16'h0555, 16'hFAAA));
    // inverted crop window drops everything that clears the body
    add_row(cfg_row(REG_CROP_BOUNDS, 64'h1000_F000_1000_F000));
    add_row(pt_row(1'b0, 16'h0800, 16'h0800));
    add_row(pt_row(1'b1, 16'h0400, 16'hFC00));

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed table
    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        drain_points();
        write_reg(rows[i].idx, rows[i].val);
      end else begin
        send_point(rows[i].m, rows[i].x, rows[i].y, rows[i].typed, rows[i].res);
      end
    end

    // random phases, each under its own calibration
    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain_points();
      configure_phase(ph);
      n_items = (ph < 3) ? 60 : 180;
      for (int k = 0; k < n_items; k++) begin
        if (k == n_items / 2) drain_points();
        m = 1'($urandom_range(0, 1));
        if (ph >= 2 && $urandom_range(0, 3) != 0) begin
          x = rand_coord('h0C00);
          y = rand_coord('h0C00);
        end else begin
          x = CW'($urandom());
          y = CW'($urandom());
        end
        send_point(m, x, y, 1'b0, BODY_RES);
      end
    end

    drain_points();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    $display("run covered %0d points over %0d calibrations: %0d kept, %0d body drops, %0d crop drops",
             n_points, N_PHASES + 4, n_kept, n_body, n_crop);
    $display("%0d results checked, %0d mismatches", n_results, n_errors);
    if (n_errors == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/lptc_pkg.sv
src/lptc_rotate.sv
src/lidar_point_transform_crop.sv
tb/sv/lidar_point_transform_crop_test.sv
